// ----- hw/rtl/pi_controller_clamped_top_macros.svh -----
// Assertion macros for the RTL of the PI controller.
`ifndef PI_CONTROLLER_CLAMPED_TOP_MACROS_SVH
`define PI_CONTROLLER_CLAMPED_TOP_MACROS_SVH

// Check a property at each rising edge, off while reset is high.
`define PICC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("picc assertion failed");

// Check a property at each rising edge, reset included.
`define PICC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("picc assertion failed");

`endif

// ----- hw/rtl/picc_pkg.sv -----
// Package of types, constants and helper functions for the PI controller.
`timescale 1ns / 1ps
package picc_pkg;

   localparam int unsigned DataWidth  = 16;
   localparam int unsigned IntegWidth = 18;
   localparam int unsigned CsrIdxWidth = 4;
   localparam int unsigned ShiftP = 4;
   localparam int unsigned ShiftI = 9;
   localparam int unsigned SumWidth = 29;

   localparam logic [CsrIdxWidth-1:0] CsrPropGain  = 4'd0;
   localparam logic [CsrIdxWidth-1:0] CsrIntegGain = 4'd1;
   localparam logic [CsrIdxWidth-1:0] CsrOutUpper  = 4'd2;
   localparam logic [CsrIdxWidth-1:0] CsrOutLower  = 4'd3;

   localparam logic ActStep  = 1'b0;
   localparam logic ActClear = 1'b1;

   typedef struct packed {
      logic signed [DataWidth-1:0] prop_gain;
      logic signed [DataWidth-1:0] integ_gain;
      logic signed [DataWidth-1:0] out_upper;
      logic signed [DataWidth-1:0] out_lower;
   } csr_type;

   typedef struct packed {
      logic                        action;
      logic signed [DataWidth-1:0] measured;
      logic signed [DataWidth-1:0] setpoint;
   } item_type;

   function automatic logic signed [DataWidth-1:0] clamp_out(
      input logic signed [SumWidth-1:0]  v,
      input logic signed [DataWidth-1:0] upper,
      input logic signed [DataWidth-1:0] lower
   );
      logic signed [SumWidth-1:0] r;
      if (v > SumWidth'(upper)) begin
         r = SumWidth'(upper);
      end else if (v < SumWidth'(lower)) begin
         r = SumWidth'(lower);
      end else begin
         r = v;
      end
      return r[DataWidth-1:0];
   endfunction

endpackage

// ----- hw/rtl/picc_req_if.sv -----
// Input channel of the PI controller: valid/ready with the step item.
`timescale 1ns / 1ps
interface picc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 action;
   logic signed [picc_pkg::DataWidth-1:0] measured;
   logic signed [picc_pkg::DataWidth-1:0] setpoint;

   modport source (output valid, output action, output measured, output setpoint,
                   input ready);
   modport sink (input valid, input action, input measured, input setpoint,
                 output ready);
endinterface

// ----- hw/rtl/picc_rsp_if.sv -----
// Result channel of the PI controller: valid/ready with the drive value.
`timescale 1ns / 1ps
interface picc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [picc_pkg::DataWidth-1:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink (input valid, input drive, output ready);
endinterface

// ----- hw/rtl/picc_datapath.sv -----
// Combinational PI step: error, both terms, integrator clamp and output clamp; also clear and zero-gain bypass.
`timescale 1ns / 1ps
module picc_datapath (
   input  picc_pkg::csr_type                         csr,
   input  picc_pkg::item_type                        item,
   input  logic signed [picc_pkg::IntegWidth-1:0]    integ,
   output logic signed [picc_pkg::DataWidth-1:0]     drive,
   output logic signed [picc_pkg::IntegWidth-1:0]    integ_next
);

   localparam int unsigned DW   = picc_pkg::DataWidth;
   localparam int unsigned IW   = picc_pkg::IntegWidth;
   localparam int unsigned PW   = 2 * DW;
   localparam int unsigned PTW  = PW - picc_pkg::ShiftP;
   localparam int unsigned ITW  = PW - picc_pkg::ShiftI;
   localparam int unsigned AW   = ITW + 1;
   localparam int unsigned LW   = DW + 1;
   localparam int unsigned SW   = picc_pkg::SumWidth;

   logic signed [DW-1:0]  err;
   logic signed [PW-1:0]  prod_p;
   logic signed [PW-1:0]  prod_i;
   logic signed [PTW-1:0] p_term;
   logic signed [ITW-1:0] i_term;
   logic signed [AW-1:0]  acc;
   logic signed [AW-1:0]  acc_hi;
   logic signed [AW-1:0]  acc_cl;
   logic signed [LW-1:0]  lim;
   logic signed [AW-1:0]  lim_pos;
   logic signed [AW-1:0]  lim_neg;
   logic signed [SW-1:0]  sum;

   always_comb begin
      err     = DW'(item.setpoint - item.measured);
      prod_p  = PW'(csr.prop_gain) * PW'(err);
      prod_i  = PW'(csr.integ_gain) * PW'(err);
      p_term  = prod_p[PW-1:picc_pkg::ShiftP];
      i_term  = prod_i[PW-1:picc_pkg::ShiftI];
      acc     = AW'(integ) + AW'(i_term);
      lim     = {csr.out_upper, 1'b0};
      lim_pos = AW'(lim);
      lim_neg = -lim_pos;
      acc_hi  = (acc > lim_pos) ? lim_pos : acc;
      acc_cl  = (acc_hi < lim_neg) ? lim_neg : acc_hi;
      sum     = SW'(p_term) + SW'(acc_cl);

      if (item.action == picc_pkg::ActClear) begin
         drive      = '0;
         integ_next = '0;
      end else if (csr.prop_gain == '0) begin
         drive      = picc_pkg::clamp_out(SW'(item.setpoint), csr.out_upper, csr.out_lower);
         integ_next = integ;
      end else begin
         drive      = picc_pkg::clamp_out(sum, csr.out_upper, csr.out_lower);
         integ_next = acc_cl[IW-1:0];
      end
   end

endmodule

// ----- hw/rtl/pi_controller_clamped_top.sv -----
// Top level of the clamped PI controller: input stage, integrator and result register.
//
//   channel   | direction | transfer condition      | payload
//   req_chan  | in        | valid && ready          | action, measured, setpoint
//   rsp_chan  | out       | valid && ready          | drive
//   csr_*     | in        | csr_we at a rising edge | csr_index, csr_wdata
//
// One item per cycle while results are taken; input stage, then output register.
// The rate is set by the integrator update, done combinationally by the datapath.
// Reset is synchronous; it clears the CSRs, integrator and both valid flags.
// A stalled result holds in the output register; the input stage still moves
// forward whenever the held result is taken in the same cycle.
`timescale 1ns / 1ps
`include "pi_controller_clamped_top_macros.svh"
module pi_controller_clamped_top (
   input  logic                                   clock,
   input  logic                                   reset,
   picc_req_if.sink                               req_chan,
   picc_rsp_if.source                             rsp_chan,
   input  logic                                   csr_we,
   input  logic [picc_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [picc_pkg::DataWidth-1:0]         csr_wdata
);

   picc_pkg::csr_type  csr_ff, csr_in;
   picc_pkg::item_type item_ff, item_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               out_valid_ff, out_valid_in;
   logic signed [picc_pkg::DataWidth-1:0]  drive_ff, drive_in;
   logic signed [picc_pkg::IntegWidth-1:0] integ_ff, integ_in;
   logic signed [picc_pkg::DataWidth-1:0]  dp_drive;
   logic signed [picc_pkg::IntegWidth-1:0] dp_integ;
   logic advance;
   logic take;

   picc_datapath u_datapath (
      .csr        (csr_ff),
      .item       (item_ff),
      .integ      (integ_ff),
      .drive      (dp_drive),
      .integ_next (dp_integ)
   );

   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.drive = drive_ff;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            picc_pkg::CsrPropGain:  csr_in.prop_gain  = csr_wdata;
            picc_pkg::CsrIntegGain: csr_in.integ_gain = csr_wdata;
            picc_pkg::CsrOutUpper:  csr_in.out_upper  = csr_wdata;
            picc_pkg::CsrOutLower:  csr_in.out_lower  = csr_wdata;
            default:                csr_in            = csr_ff;
         endcase
      end

      s1_valid_in  = take || (s1_valid_ff && !advance);
      item_in      = take ? picc_pkg::item_type'{action:   req_chan.action,
                                                 measured: req_chan.measured,
                                                 setpoint: req_chan.setpoint} : item_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      drive_in     = advance ? dp_drive : drive_ff;
      integ_in     = advance ? dp_integ : integ_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         integ_ff     <= '0;
      end else begin
         csr_ff       <= csr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         integ_ff     <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      drive_ff <= drive_in;
   end

   `PICC_ASSERT(a_clear_zeroes_integ, clock, reset, (advance && item_ff.action == picc_pkg::ActClear) |=> (integ_ff == '0 && drive_ff == '0))
   `PICC_ASSERT(a_bypass_holds_integ, clock, reset, (advance && item_ff.action == picc_pkg::ActStep && csr_ff.prop_gain == '0) |=> $stable(integ_ff))
   `PICC_ASSERT(a_advance_gives_result, clock, reset, advance |=> out_valid_ff)
   `PICC_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (!s1_valid_ff && !out_valid_ff && integ_ff == '0))

endmodule

// ----- tb/sv/tb_pi_controller_clamped_top.sv -----
// Testbench for the clamped PI controller: random and directed steps checked against a predictor.
`timescale 1ns / 1ps
module tb_pi_controller_clamped_top;

   localparam int unsigned DW = picc_pkg::DataWidth;
   localparam int unsigned IW = picc_pkg::IntegWidth;
   localparam int unsigned CW = picc_pkg::CsrIdxWidth;

   localparam int HoldAt  = 220;
   localparam int HoldLen = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid  = 1'b0;
   logic                           req_action = picc_pkg::ActStep;
   logic signed [DW-1:0]           req_meas   = '0;
   logic signed [DW-1:0]           req_sp     = '0;
   logic                           rsp_ready  = 1'b0;
   logic                           csr_we     = 1'b0;
   logic [CW-1:0]                  csr_index  = '0;
   logic [DW-1:0]                  csr_wdata  = '0;

   picc_req_if req_chan();
   picc_rsp_if rsp_chan();

   assign req_chan.valid    = req_valid;
   assign req_chan.action   = req_action;
   assign req_chan.measured = req_meas;
   assign req_chan.setpoint = req_sp;
   assign rsp_chan.ready    = rsp_ready;

   pi_controller_clamped_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // controller model: registers and integrator
   logic signed [DW-1:0]  gain_p = '0;
   logic signed [DW-1:0]  gain_i = '0;
   logic signed [DW-1:0]  upper  = '0;
   logic signed [DW-1:0]  lower  = '0;
   logic signed [IW-1:0]  integ  = '0;

   picc_pkg::item_type           step_items[$];
   logic signed [DW-1:0]         expected_drive[$];
   int                           items_taken  = 0;
   int                           offered_item = 0;
   int                           errors       = 0;
   int                           rsp_hold_left = 0;
   logic                         hold_done    = 1'b0;
   logic                         no_idle      = 1'b0;
   logic signed [DW-1:0]         want;

   function automatic logic signed [DW-1:0] limit_drive(input logic signed [39:0] v);
      logic signed [DW-1:0] r;
      if (v > upper) begin
         r = upper;
      end else if (v < lower) begin
         r = lower;
      end else begin
         r = v[DW-1:0];
      end
      return r;
   endfunction

   task automatic predict_drive(input picc_pkg::item_type it);
      logic signed [DW-1:0] err;
      logic signed [39:0]   pterm;
      logic signed [39:0]   iterm;
      logic signed [39:0]   acc;
      logic signed [39:0]   lim;
      logic signed [DW-1:0] drv;
      if (it.action == picc_pkg::ActClear) begin
         integ = '0;
         drv = '0;
      end else if (gain_p == 0) begin
         acc = it.setpoint;
         drv = limit_drive(acc);
      end else begin
         err = it.setpoint - it.measured;
         pterm = gain_p * err;
         pterm = pterm >>> picc_pkg::ShiftP;
         iterm = gain_i * err;
         iterm = iterm >>> picc_pkg::ShiftI;
         acc = integ;
         acc = acc + iterm;
         lim = upper;
         lim = lim * 2;
         if (acc > lim) acc = lim;
         if (acc < -lim) acc = -lim;
         integ = acc[IW-1:0];
         drv = limit_drive(pterm + acc);
      end
      expected_drive.push_back(drv);
   endtask

   // sender: hold an offer until its transfer, then advance
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || items_taken != offered_item) begin
         if (items_taken < step_items.size() && (no_idle || $urandom_range(99) >= 8)) begin
            req_valid    <= 1'b1;
            req_action   <= step_items[items_taken].action;
            req_meas     <= step_items[items_taken].measured;
            req_sp       <= step_items[items_taken].setpoint;
            offered_item <= items_taken;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random idles plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && items_taken >= HoldAt) begin
         hold_done <= 1'b1;
         rsp_hold_left <= HoldLen;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 8);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            predict_drive(step_items[items_taken]);
            items_taken = items_taken + 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_drive.size() == 0) begin
               $error("unexpected result: drive %0d", rsp_chan.drive);
               errors = errors + 1;
            end else begin
               want = expected_drive.pop_front();
               if (rsp_chan.drive !== want) begin
                  $error("drive mismatch: expected %0d, actual %0d", want, rsp_chan.drive);
                  errors = errors + 1;
               end
            end
         end
      end
   end

   task automatic write_csr(input logic [CW-1:0] idx, input logic [DW-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         picc_pkg::CsrPropGain:  gain_p = val;
         picc_pkg::CsrIntegGain: gain_i = val;
         picc_pkg::CsrOutUpper:  upper  = val;
         picc_pkg::CsrOutLower:  lower  = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_regs(input logic signed [DW-1:0] p, input logic signed [DW-1:0] i,
                           input logic signed [DW-1:0] u,
                           input logic signed [DW-1:0] l);
      write_csr(picc_pkg::CsrPropGain, p);
      write_csr(picc_pkg::CsrIntegGain, i);
      write_csr(picc_pkg::CsrOutUpper, u);
      write_csr(picc_pkg::CsrOutLower, l);
      write_csr(CW'($urandom_range(15, 4)), DW'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_step(input logic act, input logic signed [DW-1:0] meas,
                            input logic signed [DW-1:0] sp);
      picc_pkg::item_type it;
      it.action   = act;
      it.measured = meas;
      it.setpoint = sp;
      step_items.push_back(it);
   endtask

   task automatic wait_idle();
      while (items_taken < step_items.size() || expected_drive.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic signed [DW-1:0] pick_reg();
      logic signed [DW-1:0] v;
      case ($urandom_range(5))
         0: v = 16'sh8000;
         1: v = 16'sh7fff;
         2: v = 16'sd0;
         3: v = DW'($urandom_range(4000)) - 16'sd2000;
         default: v = DW'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic signed [DW-1:0] pick_value(input logic signed [DW-1:0] near);
      logic signed [DW-1:0] v;
      case ($urandom_range(5))
         0: v = 16'sh8000;
         1: v = 16'sh7fff;
         2, 3: v = near + DW'($urandom_range(600)) - 16'sd300;
         default: v = DW'($urandom);
      endcase
      return v;
   endfunction

   task automatic run_random(input int count);
      logic signed [DW-1:0] sp;
      for (int k = 0; k < count; k++) begin
         sp = DW'($urandom);
         if ($urandom_range(19) == 0) begin
            push_step(picc_pkg::ActClear, DW'($urandom), sp);
         end else begin
            push_step(picc_pkg::ActStep, pick_value(sp), sp);
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: bypass with a zero-width window
      push_step(picc_pkg::ActStep, 16'sh7fff, 16'sh8000);
      push_step(picc_pkg::ActClear, 16'sh8000, 16'sh7fff);
      wait_idle();

      set_regs(16'sd16, 16'sd512, 16'sd1000, -16'sd1000);
      push_step(picc_pkg::ActStep, 16'sd0, 16'sd0);
      push_step(picc_pkg::ActStep, 16'sh8000, 16'sh7fff);
      push_step(picc_pkg::ActStep, 16'sh7fff, 16'sh8000);
      push_step(picc_pkg::ActStep, 16'sd0, 16'sd500);
      push_step(picc_pkg::ActStep, 16'sd0, 16'sd3000);
      push_step(picc_pkg::ActStep, 16'sd3000, 16'sd0);
      push_step(picc_pkg::ActClear, 16'sd77, -16'sd77);
      push_step(picc_pkg::ActStep, 16'sd0, -16'sd3000);
      push_step(picc_pkg::ActStep, 16'sd0, -16'sd3000);
      wait_idle();

      set_regs(16'sd0, 16'sd100, 16'sh7fff, 16'sh8000);
      push_step(picc_pkg::ActStep, 16'sd5, 16'sh8000);
      push_step(picc_pkg::ActStep, -16'sd5, 16'sh7fff);
      push_step(picc_pkg::ActStep, 16'sd9, 16'sd123);
      wait_idle();

      set_regs(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
      push_step(picc_pkg::ActStep, 16'sh7fff, 16'sh8000);
      push_step(picc_pkg::ActStep, 16'sh8000, 16'sd0);
      push_step(picc_pkg::ActStep, 16'sd0, 16'sh7fff);
      push_step(picc_pkg::ActClear, 16'sd0, 16'sd0);
      wait_idle();

      // inverted window with a negative upper clamp
      set_regs(16'sh7fff, 16'sh7fff, -16'sd100, 16'sd100);
      push_step(picc_pkg::ActStep, 16'sd0, 16'sd5);
      push_step(picc_pkg::ActStep, 16'sd5, 16'sd0);
      push_step(picc_pkg::ActStep, 16'sd0, 16'sd0);
      wait_idle();

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 0) begin
            set_regs(16'sd24, 16'sd300, 16'sd2500, -16'sd2500);
         end else begin
            set_regs(($urandom_range(5) == 0) ? 16'sd0 : pick_reg(), pick_reg(), pick_reg(),
                     pick_reg());
         end
         no_idle = (ph == 3);
         run_random(105);
      end
      no_idle = 1'b0;

      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
